// ===== hw/rtl/rsa_pkg.sv =====
// Package: shared widths, register indexes and reset values for the RSA exponentiation block.
`timescale 1ns / 1ps
package rsa_pkg;
  localparam int MOD_BITS_DEF = 63;
  localparam int REG_W = 63;
  localparam int VAL_W = 63;
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [IDX_W-1:0] REG_PUB_EXP = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRV_EXP = 2'd2;
  localparam logic [REG_W-1:0] PUB_EXP_RST = 63'd65537;

  // control from the sequencer: reduction chain start and the current exponent bit
  typedef struct packed {
    logic start;
    logic bit_sel;
  } rsa_ctl_t;
endpackage

// ===== hw/rtl/rsa_if.sv =====
// Interfaces: input and result channels of the RSA exponentiation block.
`timescale 1ns / 1ps
interface rsa_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [rsa_pkg::VAL_W-1:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface rsa_out_if;
  logic                      valid;
  logic                      ready;
  logic [rsa_pkg::VAL_W-1:0] result_value;
  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

// ===== hw/rtl/rsa_modular_exponentiation.sv =====
// Top level: RSA modular exponentiation by right-to-left square and multiply.
//   channel  dir  payload
//   in_      in   kind, value
//   out_     out  result_value
//   cfg_     in   we, index, data
// One item at a time. The base is reduced by a 63-cell subtract row, then each
// exponent bit costs a square and, when set, a multiply on one shared
// bit-serial multiplier.
// Reset is synchronous, active low, and restores the register defaults.
// The result is held in an output register; the next item is taken once it leaves.
`timescale 1ns / 1ps
module rsa_modular_exponentiation #(
  parameter int MOD_BITS = rsa_pkg::MOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rsa_in_if.sink                           in_ch,
  rsa_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [rsa_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rsa_pkg::REG_W-1:0]        cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_RED, S_MUL, S_WMUL, S_SQR, S_WSQR, S_OUT} st_t;
  st_t st_r;

  logic [MOD_BITS-1:0]      mod_r;
  logic [rsa_pkg::REG_W-1:0] pub_r, prv_r, exp_r;
  logic [MOD_BITS-1:0]      acc_r, base_r;
  logic [rsa_pkg::VAL_W-1:0] res_r, val_r;
  logic                     ovalid_r;
  logic                     red_go_r, mul_go_r;
  logic [MOD_BITS-1:0]      mul_a_r, mul_b_r;
  logic                     red_done, mul_done;
  logic [MOD_BITS-1:0]      red, prod;
  rsa_pkg::rsa_ctl_t        ctl;

  assign ctl.start   = red_go_r;
  assign ctl.bit_sel = exp_r[0];

  rsa_modmul_chain #(.MOD_BITS(MOD_BITS)) u_chain (
    .clk(clk), .rst_n(rst_n), .start(ctl.start), .value(val_r), .m(mod_r),
    .done(red_done), .red(red)
  );

  rsa_modmul #(.MOD_BITS(MOD_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go_r), .a(mul_a_r), .b(mul_b_r), .m(mod_r),
    .done(mul_done), .prod(prod)
  );

  assign in_ch.ready         = (st_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.result_value = res_r;

  logic [MOD_BITS-1:0] cfg_m;
  assign cfg_m = cfg_data[MOD_BITS-1:0];

  // config registers, sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r    <= MOD_BITS'(1);
      pub_r    <= rsa_pkg::PUB_EXP_RST;
      prv_r    <= rsa_pkg::REG_W'(1);
      st_r     <= S_IDLE;
      ovalid_r <= 1'b0;
      red_go_r <= 1'b0;
      mul_go_r <= 1'b0;
    end else begin
      red_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rsa_pkg::REG_MODULUS: mod_r <= (cfg_m == '0) ? MOD_BITS'(1) : cfg_m;
          rsa_pkg::REG_PUB_EXP: pub_r <= cfg_data;
          rsa_pkg::REG_PRV_EXP: prv_r <= cfg_data;
          default: ;
        endcase
      end
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            val_r    <= in_ch.value;
            exp_r    <= in_ch.kind ? prv_r : pub_r;
            acc_r    <= MOD_BITS'(1);
            red_go_r <= 1'b1;
            st_r     <= S_RED;
          end
        end
        S_RED: begin
          if (red_done) begin
            base_r <= red;
            st_r   <= S_MUL;
          end
        end
        S_MUL: begin
          if (exp_r == '0) begin
            res_r    <= rsa_pkg::VAL_W'(acc_r);
            ovalid_r <= 1'b1;
            st_r     <= S_OUT;
          end else if (ctl.bit_sel) begin
            mul_a_r  <= acc_r;
            mul_b_r  <= base_r;
            mul_go_r <= 1'b1;
            st_r     <= S_WMUL;
          end else begin
            st_r <= S_SQR;
          end
        end
        S_WMUL: begin
          if (mul_done) begin
            acc_r <= prod;
            st_r  <= S_SQR;
          end
        end
        S_SQR: begin
          mul_a_r  <= base_r;
          mul_b_r  <= base_r;
          mul_go_r <= 1'b1;
          st_r     <= S_WSQR;
        end
        S_WSQR: begin
          if (mul_done) begin
            base_r <= prod;
            exp_r  <= {1'b0, exp_r[rsa_pkg::REG_W-1:1]};
            st_r   <= S_MUL;
          end
        end
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/rsa_cell.sv =====
// One cell of the reduction chain: a conditional subtract of its stage's multiple of m.
`timescale 1ns / 1ps
module rsa_cell #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] d_in,
  input  logic [W-1:0] m_in,
  input  logic         v_in,
  output logic [W-1:0] d_out,
  output logic [W-1:0] m_out,
  output logic         v_out
);
  logic [W-1:0] d_r, m_r;
  logic         v_r;
  logic [W-1:0] d_nxt;

  // subtract the shifted modulus when it fits
  always_comb begin
    d_nxt = (d_in >= m_in) ? d_in - m_in : d_in;
  end

  // data moves every cycle; only the valid bit is cleared by reset
  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    m_r <= {1'b0, m_in[W-1:1]};
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
  end

  assign d_out = d_r;
  assign m_out = m_r;
  assign v_out = v_r;
endmodule

// ===== hw/rtl/rsa_modmul.sv =====
// Bit-serial modular multiplier: one double-and-add step of acc per cycle.
`timescale 1ns / 1ps
module rsa_modmul #(
  parameter int MOD_BITS = rsa_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [MOD_BITS-1:0] a,
  input  logic [MOD_BITS-1:0] b,
  input  logic [MOD_BITS-1:0] m,
  output logic                done,
  output logic [MOD_BITS-1:0] prod
);
  localparam int CW = $clog2(MOD_BITS + 1);
  logic [MOD_BITS-1:0] acc_r, acc_nxt, b_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic [MOD_BITS:0]   dbl, dred, sum;

  // acc = 2acc mod m, then + a mod m if the top bit of b is set
  always_comb begin
    dbl  = {acc_r, 1'b0};
    dred = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum  = dred + {1'b0, a};
    if (b_r[MOD_BITS-1]) begin
      acc_nxt = (sum >= {1'b0, m}) ? MOD_BITS'(sum - {1'b0, m}) : sum[MOD_BITS-1:0];
    end else begin
      acc_nxt = dred[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MOD_BITS);
        acc_r  <= '0;
        b_r    <= b;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[MOD_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign prod = acc_r;
endmodule

// ===== hw/rtl/rsa_modmul_chain.sv =====
// Base reduction chain: a row of subtract cells that reduces the input value modulo m.
`timescale 1ns / 1ps
module rsa_modmul_chain #(
  parameter int MOD_BITS = rsa_pkg::MOD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rsa_pkg::VAL_W-1:0]     value,
  input  logic [MOD_BITS-1:0]           m,
  output logic                          done,
  output logic [MOD_BITS-1:0]           red
);
  localparam int W = rsa_pkg::VAL_W + MOD_BITS;
  localparam int N = rsa_pkg::VAL_W;
  logic [W-1:0] d [0:N];
  logic [W-1:0] mm [0:N];
  logic         v [0:N];

  // modulus shifted up so each cell strips one quotient bit
  assign d[0]  = {{MOD_BITS{1'b0}}, value};
  assign mm[0] = {m, {(N-1){1'b0}}, 1'b0} >> 1;
  assign v[0]  = start;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rsa_cell #(.W(W)) u_cell (
      .clk(clk), .rst_n(rst_n), .d_in(d[i]), .m_in(mm[i]), .v_in(v[i]),
      .d_out(d[i+1]), .m_out(mm[i+1]), .v_out(v[i+1])
    );
  end

  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= v[N];
  end
  assign done = v[N] & ~done_r;
  assign red  = d[N][MOD_BITS-1:0];
endmodule
